[hdl/sorted_id_pool_allocator_core_macros.svh]
// assertion helpers for the id pool allocator
`ifndef SORTED_ID_POOL_ALLOCATOR_CORE_MACROS_SVH
`define SORTED_ID_POOL_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SIPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SIPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/sipa_pkg.sv]
package sipa_pkg;

	localparam int DEF_ID_WIDTH   = 16;
	localparam int DEF_POOL_DEPTH = 256;
	localparam int DEF_BLOCK_SIZE = 16;

	localparam int IN_ID_WIDTH  = 16;
	localparam int GRANT_WIDTH  = 16;
	localparam int STATUS_WIDTH = 3;

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_BORROWED  = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_EXHAUSTED = 3'd4
	} status_t;

	localparam logic ACT_BORROW = 1'b0;
	localparam logic ACT_GIVE   = 1'b1;

	typedef enum logic [1:0] {
		RD_HEAD,
		RD_K,
		RD_KM1
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_FILL,
		WR_SHIFT,
		WR_ID
	} wr_sel_t;

	typedef enum logic [3:0] {
		S_INIT_FILL,
		S_IDLE,
		S_DECODE,
		S_REFILL,
		S_BORROW_RD,
		S_BORROW_OUT,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR
	} state_t;

	typedef struct packed {
		logic    load;
		logic    k_clr;
		logic    k_inc;
		logic    k_dec;
		logic    mark_pos;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    fill_done;
		logic    pop;
		logic    push;
		logic    res_en;
		status_t res_status;
		logic    res_grant;
	} cmd_t;

	typedef struct packed {
		logic is_give;
		logic count_zero;
		logic exhausted;
		logic full;
		logic scan_end;
		logic cmp_ge;
		logic cmp_eq;
		logic fill_last;
		logic at_pos;
	} stat_t;

endpackage

[hdl/sipa_ctrl.sv]
module sipa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sipa_pkg::stat_t stat,
	output sipa_pkg::cmd_t  cmd
);

	sipa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sipa_pkg::S_INIT_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sipa_pkg::S_INIT_FILL: begin
				if (stat.fill_last) state_d = sipa_pkg::S_IDLE;
			end
			sipa_pkg::S_IDLE: begin
				if (start) state_d = sipa_pkg::S_DECODE;
			end
			sipa_pkg::S_DECODE: begin
				priority if (stat.is_give) state_d = sipa_pkg::S_SCAN_RD;
				else if (stat.count_zero && stat.exhausted) state_d = sipa_pkg::S_IDLE;
				else if (stat.count_zero) state_d = sipa_pkg::S_REFILL;
				else state_d = sipa_pkg::S_BORROW_RD;
			end
			sipa_pkg::S_REFILL: begin
				if (stat.fill_last) state_d = sipa_pkg::S_BORROW_RD;
			end
			sipa_pkg::S_BORROW_RD:  state_d = sipa_pkg::S_BORROW_OUT;
			sipa_pkg::S_BORROW_OUT: state_d = sipa_pkg::S_IDLE;
			sipa_pkg::S_SCAN_RD: begin
				priority if (!stat.scan_end) state_d = sipa_pkg::S_SCAN_CMP;
				else if (stat.full) state_d = sipa_pkg::S_IDLE;
				else state_d = sipa_pkg::S_SHIFT_RD;
			end
			sipa_pkg::S_SCAN_CMP: begin
				priority if (stat.cmp_eq) state_d = sipa_pkg::S_IDLE;
				else if (stat.cmp_ge && stat.full) state_d = sipa_pkg::S_IDLE;
				else if (stat.cmp_ge) state_d = sipa_pkg::S_SHIFT_RD;
				else state_d = sipa_pkg::S_SCAN_RD;
			end
			sipa_pkg::S_SHIFT_RD: begin
				if (stat.at_pos) state_d = sipa_pkg::S_IDLE;
				else state_d = sipa_pkg::S_SHIFT_WR;
			end
			sipa_pkg::S_SHIFT_WR: state_d = sipa_pkg::S_SHIFT_RD;
			default: state_d = sipa_pkg::S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd        = '0;
		cmd.rd_sel = sipa_pkg::RD_K;
		cmd.wr_sel = sipa_pkg::WR_FILL;
		cmd.res_status = sipa_pkg::ST_BORROWED;
		busy       = 1'b1;
		unique case (state_q)
			sipa_pkg::S_INIT_FILL, sipa_pkg::S_REFILL: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = sipa_pkg::WR_FILL;
				if (stat.fill_last) begin
					cmd.fill_done = 1'b1;
					cmd.k_clr     = 1'b1;
				end else begin
					cmd.k_inc = 1'b1;
				end
			end
			sipa_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load  = 1'b1;
					cmd.k_clr = 1'b1;
				end
			end
			sipa_pkg::S_DECODE: begin
				if (!stat.is_give && stat.count_zero && stat.exhausted) begin
					cmd.res_en     = 1'b1;
					cmd.res_status = sipa_pkg::ST_EXHAUSTED;
				end
			end
			sipa_pkg::S_BORROW_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = sipa_pkg::RD_HEAD;
			end
			sipa_pkg::S_BORROW_OUT: begin
				cmd.res_en     = 1'b1;
				cmd.res_status = sipa_pkg::ST_BORROWED;
				cmd.res_grant  = 1'b1;
				cmd.pop        = 1'b1;
			end
			sipa_pkg::S_SCAN_RD: begin
				priority if (!stat.scan_end) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = sipa_pkg::RD_K;
				end else if (stat.full) begin
					cmd.res_en     = 1'b1;
					cmd.res_status = sipa_pkg::ST_FULL;
				end else begin
					cmd.mark_pos = 1'b1;
				end
			end
			sipa_pkg::S_SCAN_CMP: begin
				priority if (stat.cmp_eq) begin
					cmd.res_en     = 1'b1;
					cmd.res_status = sipa_pkg::ST_DUPLICATE;
				end else if (stat.cmp_ge && stat.full) begin
					cmd.res_en     = 1'b1;
					cmd.res_status = sipa_pkg::ST_FULL;
				end else if (stat.cmp_ge) begin
					cmd.mark_pos = 1'b1;
				end else begin
					cmd.k_inc = 1'b1;
				end
			end
			sipa_pkg::S_SHIFT_RD: begin
				if (stat.at_pos) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_sel     = sipa_pkg::WR_ID;
					cmd.push       = 1'b1;
					cmd.res_en     = 1'b1;
					cmd.res_status = sipa_pkg::ST_INSERTED;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = sipa_pkg::RD_KM1;
				end
			end
			sipa_pkg::S_SHIFT_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = sipa_pkg::WR_SHIFT;
				cmd.k_dec  = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

[hdl/sipa_dp.sv]
module sipa_dp #(
	parameter int ID_WIDTH   = sipa_pkg::DEF_ID_WIDTH,
	parameter int POOL_DEPTH = sipa_pkg::DEF_POOL_DEPTH,
	parameter int BLOCK_SIZE = sipa_pkg::DEF_BLOCK_SIZE
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sipa_pkg::cmd_t                     cmd,
	output sipa_pkg::stat_t                    stat,
	input  logic                               action,
	input  logic [sipa_pkg::IN_ID_WIDTH-1:0]   returned_id,
	output logic                               done,
	output logic [sipa_pkg::GRANT_WIDTH-1:0]   granted_id,
	output logic [sipa_pkg::STATUS_WIDTH-1:0]  status
);

	localparam int AW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CW  = $clog2(POOL_DEPTH + 1);
	localparam int NFW = (ID_WIDTH + 1 > 9) ? ID_WIDTH + 1 : 9;
	localparam int FILL_CNT = (BLOCK_SIZE < POOL_DEPTH) ? BLOCK_SIZE : POOL_DEPTH;
	localparam logic [NFW:0] ID_SPACE = {{NFW{1'b0}}, 1'b1} << ID_WIDTH;

	logic [ID_WIDTH-1:0] mem [POOL_DEPTH];
	logic [ID_WIDTH-1:0] rd_data_q;

	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [NFW-1:0]      nf_q;
	logic [CW-1:0]       k_q;
	logic [CW-1:0]       pos_q;
	logic [ID_WIDTH-1:0] id_q;
	logic                action_q;

	logic [ID_WIDTH-1:0]             id_in;
	logic [sipa_pkg::GRANT_WIDTH-1:0] grant_bits;
	logic [CW-1:0]       km1;
	logic [CW-1:0]       rd_lidx;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [ID_WIDTH-1:0] wr_data;
	logic [ID_WIDTH-1:0] fill_val;
	logic [NFW:0]        nf_sum;

	// mask the incoming id to the id width
	for (genvar gi = 0; gi < ID_WIDTH; gi++) begin : g_id_in
		if (gi < sipa_pkg::IN_ID_WIDTH) begin : g_bit
			assign id_in[gi] = returned_id[gi];
		end else begin : g_zero
			assign id_in[gi] = 1'b0;
		end
	end

	// low bits of the stored id for the grant port
	for (genvar gi = 0; gi < sipa_pkg::GRANT_WIDTH; gi++) begin : g_grant
		if (gi < ID_WIDTH) begin : g_bit
			assign grant_bits[gi] = rd_data_q[gi];
		end else begin : g_zero
			assign grant_bits[gi] = 1'b0;
		end
	end

	// logical index to physical address, ring around the head
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] lidx);
		logic [AW:0] sum;
		sum = {1'b0, head} + {1'b0, lidx};
		if (sum >= (AW+1)'(POOL_DEPTH)) begin
			sum = sum - (AW+1)'(POOL_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign km1 = k_q - 1'b1;

	always_comb begin
		unique case (cmd.rd_sel)
			sipa_pkg::RD_HEAD: rd_lidx = '0;
			sipa_pkg::RD_K:    rd_lidx = k_q;
			sipa_pkg::RD_KM1:  rd_lidx = km1;
			default:           rd_lidx = k_q;
		endcase
	end

	assign rd_addr  = phys(head_q, rd_lidx[AW-1:0]);
	assign wr_addr  = phys(head_q, k_q[AW-1:0]);
	assign fill_val = nf_q[ID_WIDTH-1:0] + ID_WIDTH'(k_q);

	always_comb begin
		unique case (cmd.wr_sel)
			sipa_pkg::WR_FILL:  wr_data = fill_val;
			sipa_pkg::WR_SHIFT: wr_data = rd_data_q;
			sipa_pkg::WR_ID:    wr_data = id_q;
			default:            wr_data = id_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			id_q     <= id_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			nf_q    <= '0;
			k_q     <= '0;
			pos_q   <= '0;
		end else begin
			priority if (cmd.k_clr) k_q <= '0;
			else if (cmd.k_inc) k_q <= k_q + 1'b1;
			else if (cmd.k_dec) k_q <= km1;
			else if (cmd.mark_pos) k_q <= count_q;

			if (cmd.mark_pos) pos_q <= k_q;

			if (cmd.fill_done) begin
				count_q <= CW'(FILL_CNT);
				nf_q    <= nf_q + NFW'(FILL_CNT);
			end else if (cmd.pop) begin
				count_q <= count_q - 1'b1;
				if (head_q == AW'(POOL_DEPTH - 1)) head_q <= '0;
				else head_q <= head_q + 1'b1;
			end else if (cmd.push) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.res_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_en) begin
			status     <= cmd.res_status;
			granted_id <= cmd.res_grant ? grant_bits : '0;
		end
	end

	assign nf_sum = {1'b0, nf_q} + (NFW+1)'(FILL_CNT);

	always_comb begin
		stat.is_give    = (action_q == sipa_pkg::ACT_GIVE);
		stat.count_zero = (count_q == '0);
		stat.exhausted  = (nf_sum > ID_SPACE);
		stat.full       = (count_q == CW'(POOL_DEPTH));
		stat.scan_end   = (k_q == count_q);
		stat.cmp_ge     = (rd_data_q >= id_q);
		stat.cmp_eq     = (rd_data_q == id_q);
		stat.fill_last  = (k_q == CW'(FILL_CNT - 1));
		stat.at_pos     = (k_q == pos_q);
	end

endmodule

[hdl/sorted_id_pool_allocator_core.sv]
// channel   ports                              transfer
// command   start, action, returned_id, busy   rising edge with start high and busy low
// result    done, granted_id, status           rising edge ending the one cycle done is high
//
// one item in flight at a time; a borrow from a non-empty list steps through decode, a head read
// and the pop before done; an empty list is first refilled with F ids, F = min(BLOCK_SIZE, POOL_DEPTH)
// a give-back runs a scan to the sorted slot, then a shift of the upper entries, one memory
// read and one write per entry
// after reset the list is filled with 0..F-1, one entry a cycle, busy held high while it fills
// no receiver stall: the result shows for one cycle, the next item may transfer in it

`include "sorted_id_pool_allocator_core_macros.svh"

module sorted_id_pool_allocator_core #(
	parameter int ID_WIDTH   = sipa_pkg::DEF_ID_WIDTH,
	parameter int POOL_DEPTH = sipa_pkg::DEF_POOL_DEPTH,
	parameter int BLOCK_SIZE = sipa_pkg::DEF_BLOCK_SIZE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              action,
	input  logic [sipa_pkg::IN_ID_WIDTH-1:0]  returned_id,
	output logic                              done,
	output logic [sipa_pkg::GRANT_WIDTH-1:0]  granted_id,
	output logic [sipa_pkg::STATUS_WIDTH-1:0] status
);

	// command and status between sequencer and datapath
	sipa_pkg::cmd_t  cmd;
	sipa_pkg::stat_t stat;

	// sequencer: init fill, borrow, scan and shift steps
	sipa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// list memory, head pointer, counters and result register
	sipa_dp #(
		.ID_WIDTH   (ID_WIDTH),
		.POOL_DEPTH (POOL_DEPTH),
		.BLOCK_SIZE (BLOCK_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (action),
		.returned_id (returned_id),
		.done        (done),
		.granted_id  (granted_id),
		.status      (status)
	);

	// only a borrow carries an id
	`SIPA_ASSERT_NOW(a_grant_zero, clk, arst_n,
		done && (status != sipa_pkg::ST_BORROWED), granted_id == '0,
		"non-zero id on a result that is not a borrow")

	// a transfer in always takes the block out of idle
	`SIPA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy,
		"block not busy after a command transfer")

	// each result is a single-cycle strobe
	`SIPA_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done,
		"result strobe held for more than one cycle")

	// the result comes with the return to idle
	`SIPA_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy,
		"result shown while still busy")

endmodule
